// ----- src/hkdc_pkg.sv -----
// ----------------------------------------------------------------------------
// hkdc_pkg: shared types and constants of the key dedup counter
// Table geometry, request and status codes, beat payload structs.
// ----------------------------------------------------------------------------
package hkdc_pkg;

    localparam int unsigned TableDepth = 1024;
    localparam int unsigned IdxW       = $clog2(TableDepth);
    localparam int unsigned TotW       = IdxW + 1;
    // insert refused when 100*(total+1) > 95*depth
    localparam logic [TotW+7:0] FullLimit = (TotW+8)'((95 * TableDepth) / 100);
    // index of the last median scan (depth+2 scans in all)
    localparam logic [IdxW:0]   MedLastIter = (IdxW+1)'(TableDepth + 1);

    localparam logic [1:0] FUNC_COUNT  = 2'd0;
    localparam logic [1:0] FUNC_CLAIM  = 2'd1;
    localparam logic [1:0] FUNC_MEDIAN = 2'd2;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_MATCHED   = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_LONG      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_WRITTEN   = 3'd6;

    localparam logic [2:0] REG_BOTH     = 3'd0;
    localparam logic [2:0] REG_ABUND    = 3'd1;
    localparam logic [2:0] REG_MIN_LEN  = 3'd2;
    localparam logic [2:0] REG_MAX_LEN  = 3'd3;
    localparam logic [2:0] REG_MIN_UNIQ = 3'd4;
    localparam logic [2:0] REG_MAX_UNIQ = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key_plus_low;
        logic [63:0] key_plus_high;
        logic [63:0] key_minus_low;
        logic [63:0] key_minus_high;
        logic [30:0] abundance;
        logic [31:0] seq_length;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] cluster_count;
        logic        selected;
        logic [9:0]  bucket;
        logic [32:0] median_doubled;
        logic [10:0] unique_keys;
        logic [31:0] largest_count;
    } t_out;

    // one table entry
    typedef struct packed {
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [31:0] count;
        logic        written;
    } t_entry;

endpackage

// ----- src/hkdc_table.sv -----
// ----------------------------------------------------------------------------
// hkdc_table: entry memory with a clearing pass
// One write port, one read port, read data registered. After reset a clearing
// pass writes every entry to zero; o_busy stays high meanwhile.
// ----------------------------------------------------------------------------
module hkdc_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [hkdc_pkg::IdxW-1:0]         i_waddr,
    input  hkdc_pkg::t_entry                  i_wdata,
    input  logic [hkdc_pkg::IdxW-1:0]         i_raddr,
    output hkdc_pkg::t_entry                  o_rdata,
    output logic                              o_busy
);
    import hkdc_pkg::*;

    t_entry                 r_mem [TableDepth];
    t_entry                 r_data;
    logic [IdxW-1:0]        r_clr_addr;
    logic                   r_clr_busy;
    logic                   w_we;
    logic [IdxW-1:0]        w_addr;
    t_entry                 w_data;

    // clearing pass owns the write port until it is done
    assign w_we   = r_clr_busy || i_we;
    assign w_addr = r_clr_busy ? r_clr_addr : i_waddr;
    assign w_data = r_clr_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IdxW'(TableDepth - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_rdata = r_data;
    assign o_busy  = r_clr_busy;

endmodule

// ----- src/hash_key_dedup_counter_unit.sv -----
// ----------------------------------------------------------------------------
// hash_key_dedup_counter_unit: linear-probing key counter
// Count/claim walk the table one probe step at a time (read, wait, check); with
// both strands enabled a missed plus walk is followed by the minus walk. Median
// takes up to depth+2 scans of the table through the single memory read port.
// One request at a time; the next is taken at the earliest in the cycle the
// result beat leaves. Reset restores config defaults and clears totals, then a
// clearing pass zeroes the table before input.
// ----------------------------------------------------------------------------
module hash_key_dedup_counter_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hkdc_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output hkdc_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    import hkdc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_CHECK, S_MED_READ, S_MED_SCAN, S_MED_EVAL, S_OUT
    } t_state;

    t_state            r_state;
    t_in               r_req;
    logic              r_minus;
    logic [IdxW-1:0]   r_addr;
    logic [IdxW:0]     r_steps;
    logic [TotW-1:0]   r_total;
    logic [31:0]       r_max;
    logic              r_both, r_abund;
    logic [31:0]       r_min_len, r_max_len, r_min_uniq, r_max_uniq;
    t_out              r_out;
    logic              r_out_valid;
    // first empty slot of plus walk
    logic [IdxW-1:0]   r_plus_slot;
    logic              r_plus_empty;

    // median scan
    logic [32:0]       r_cand, r_above, r_below;
    logic [TotW-1:0]   r_ac, r_bc, r_cc;
    logic [IdxW:0]     r_iter;

    logic              w_we;
    logic [IdxW-1:0]   w_waddr, w_raddr;
    t_entry            w_wdata, w_rd;
    logic              w_clr_busy;

    hkdc_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd),
        .o_busy  (w_clr_busy)
    );

    assign w_raddr = r_addr;
    assign o_ready = (r_state == S_IDLE) && !w_clr_busy && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    logic [63:0] w_klo, w_khi;
    logic        w_hit, w_empty;
    logic [31:0] w_ab;
    logic [32:0] w_sum;
    logic [31:0] w_newc;
    logic        w_full;
    logic [TotW+7:0] w_tot1;
    logic [32:0] w_v;
    logic [TotW:0] w_hi_side, w_lo_side;
    logic [IdxW-1:0] w_ins_slot;
    logic        w_ins_empty;
    logic        w_med_done;
    logic [32:0] w_med_val, w_cand_next;
    t_out        w_pre_out;
    t_state      w_pre_state;

    always_comb begin
        w_klo   = r_minus ? r_req.key_minus_low  : r_req.key_plus_low;
        w_khi   = r_minus ? r_req.key_minus_high : r_req.key_plus_high;
        w_empty = (w_rd.count == 32'd0);
        w_hit   = !w_empty && w_rd.key_low == w_klo && w_rd.key_high == w_khi;
        w_ab    = (r_abund && r_req.abundance != 31'd0) ? {1'b0, r_req.abundance} : 32'd1;
        w_sum   = {1'b0, w_rd.count} + {1'b0, w_ab};
        w_newc  = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        w_tot1  = (TotW+8)'(r_total) + 1'b1;
        w_full  = w_tot1 > FullLimit;
        w_v     = {1'b0, w_rd.count};
        w_hi_side = (TotW+1)'(r_ac) + (TotW+1)'(r_cc);
        w_lo_side = (TotW+1)'(r_bc) + (TotW+1)'(r_cc);
        // insert goes to the first empty slot of the plus walk
        w_ins_slot  = r_minus ? r_plus_slot  : r_addr;
        w_ins_empty = r_minus ? r_plus_empty : w_empty;
    end

    // median decision at the end of one scan
    always_comb begin
        w_med_done  = 1'b0;
        w_med_val   = '0;
        w_cand_next = r_cand;
        if (r_ac == '0 && r_bc == '0 && r_cc == '0) begin
            w_med_done = 1'b1;
        end else if (w_hi_side >= (TotW+1)'(r_bc)) begin
            if ((TotW+1)'(r_ac) <= w_lo_side) begin
                w_med_done = 1'b1;
                if ((TotW+1)'(r_ac) == w_lo_side)
                    w_med_val = r_cand + r_above;
                else if (w_hi_side == (TotW+1)'(r_bc))
                    w_med_val = r_below + r_cand;
                else
                    w_med_val = {r_cand[31:0], 1'b0};
            end else begin
                w_cand_next = r_above;
            end
        end else begin
            w_cand_next = r_below;
        end
        if (!w_med_done && r_iter == MedLastIter) begin
            w_med_done = 1'b1;
            w_med_val  = {w_cand_next[31:0], 1'b0};
        end
    end

    // first status and next state of an accepted request
    always_comb begin
        w_pre_out   = '0;
        w_pre_state = S_OUT;
        if (i_data.func == FUNC_MEDIAN) begin
            w_pre_state = S_MED_READ;
        end else if (i_data.func == FUNC_COUNT || i_data.func == FUNC_CLAIM) begin
            if (i_data.seq_length < r_min_len) begin
                w_pre_out.status = ST_SHORT;
            end else if (i_data.seq_length > r_max_len) begin
                w_pre_out.status = ST_LONG;
            end else begin
                w_pre_state = S_READ;
            end
        end else begin
            w_pre_out.status = ST_NOT_FOUND;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_rd;
        if (r_state == S_CHECK && r_req.func == FUNC_COUNT) begin
            if (w_hit) begin
                w_we          = 1'b1;
                w_wdata.count = w_newc;
            end else if ((w_empty || r_steps[IdxW]) && !(r_both && !r_minus)
                         && !w_full && w_ins_empty) begin
                w_we    = 1'b1;
                w_waddr = w_ins_slot;
                w_wdata = '{key_low: r_req.key_plus_low, key_high: r_req.key_plus_high,
                            count: w_ab, written: 1'b0};
            end
        end else if (r_state == S_CHECK && r_req.func == FUNC_CLAIM && w_hit
                     && !w_rd.written) begin
            w_we            = 1'b1;
            w_wdata.written = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_max       <= '0;
            r_both      <= 1'b0;
            r_abund     <= 1'b0;
            r_min_len   <= 32'd1;
            r_max_len   <= 32'hFFFF_FFFF;
            r_min_uniq  <= 32'd1;
            r_max_uniq  <= 32'hFFFF_FFFF;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BOTH:     r_both     <= i_cfg_data[0];
                    REG_ABUND:    r_abund    <= i_cfg_data[0];
                    REG_MIN_LEN:  r_min_len  <= i_cfg_data;
                    REG_MAX_LEN:  r_max_len  <= i_cfg_data;
                    REG_MIN_UNIQ: r_min_uniq <= i_cfg_data;
                    REG_MAX_UNIQ: r_max_uniq <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req   <= i_data;
                        r_minus <= 1'b0;
                        r_steps <= '0;
                        r_addr  <= (i_data.func == FUNC_MEDIAN) ? '0
                                   : i_data.key_plus_low[IdxW-1:0];
                        r_out   <= w_pre_out;
                        r_plus_empty <= 1'b0;
                        r_cand  <= 33'd1;
                        r_iter  <= '0;
                        r_ac <= '0; r_bc <= '0; r_cc <= '0;
                        r_state <= w_pre_state;
                    end
                end
                S_READ: r_state <= S_WAIT;
                S_WAIT: r_state <= S_CHECK;
                S_CHECK: begin
                    if (w_hit) begin
                        r_out.bucket <= 10'(r_addr);
                        if (r_req.func == FUNC_COUNT) begin
                            r_out.status        <= ST_MATCHED;
                            r_out.cluster_count <= w_newc;
                            if (w_newc > r_max) r_max <= w_newc;
                        end else begin
                            r_out.cluster_count <= w_rd.count;
                            if (w_rd.written) begin
                                r_out.status <= ST_WRITTEN;
                            end else begin
                                r_out.status   <= ST_MATCHED;
                                r_out.selected <= w_rd.count >= r_min_uniq
                                                  && w_rd.count <= r_max_uniq;
                            end
                        end
                        r_state <= S_OUT;
                    end else if (w_empty || r_steps[IdxW]) begin
                        // walk ended without a hit
                        if (!r_minus) begin
                            r_plus_slot  <= r_addr;
                            r_plus_empty <= w_empty;
                        end
                        if (r_both && !r_minus) begin
                            r_minus <= 1'b1;
                            r_steps <= '0;
                            r_addr  <= r_req.key_minus_low[IdxW-1:0];
                            r_state <= S_READ;
                        end else if (r_req.func == FUNC_CLAIM) begin
                            r_out.status <= ST_NOT_FOUND;
                            r_state      <= S_OUT;
                        end else if (w_full || !w_ins_empty) begin
                            r_out.status <= ST_FULL;
                            r_state      <= S_OUT;
                        end else begin
                            r_out.status        <= ST_NEW;
                            r_out.cluster_count <= w_ab;
                            r_out.bucket        <= 10'(w_ins_slot);
                            r_total             <= r_total + 1'b1;
                            if (w_ab > r_max) r_max <= w_ab;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_MED_READ: begin
                    // address 0 issued; data arrives next cycle
                    r_addr  <= r_addr + 1'b1;
                    r_steps <= '0;
                    r_state <= S_MED_SCAN;
                end
                S_MED_SCAN: begin
                    if (w_v != 33'd0) begin
                        if (w_v > r_cand) begin
                            if (r_ac == '0 || w_v < r_above) r_above <= w_v;
                            r_ac <= r_ac + 1'b1;
                        end else if (w_v < r_cand) begin
                            if (r_bc == '0 || w_v > r_below) r_below <= w_v;
                            r_bc <= r_bc + 1'b1;
                        end else begin
                            r_cc <= r_cc + 1'b1;
                        end
                    end
                    r_addr  <= r_addr + 1'b1;
                    r_steps <= r_steps + 1'b1;
                    if (r_steps == (IdxW+1)'(TableDepth - 1)) r_state <= S_MED_EVAL;
                end
                S_MED_EVAL: begin
                    r_addr <= '0;
                    r_ac <= '0; r_bc <= '0; r_cc <= '0;
                    r_iter <= r_iter + 1'b1;
                    r_cand <= w_cand_next;
                    if (w_med_done) begin
                        r_out.status         <= ST_MATCHED;
                        r_out.median_doubled <= w_med_val;
                        r_state              <= S_OUT;
                    end else begin
                        r_state <= S_MED_READ;
                    end
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out.unique_keys   <= 11'(r_total);
                    r_out.largest_count <= r_max;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/sv/tb_hash_key_dedup_counter_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_key_dedup_counter_unit: self-checking bench of the key dedup counter
// Drives count, claim, median and unknown requests through the valid/ready
// input, predicts each result from a behavioral copy of the probing table,
// and compares every output beat field by field. Runs directed cases, random
// phases under several register settings, and a final fill up to the limit.
// ----------------------------------------------------------------------------
module tb_hash_key_dedup_counter_unit;
    import hkdc_pkg::*;

    localparam int unsigned CycleLimit = 100_000_000;
    localparam logic [31:0] AllOnes    = 32'hFFFF_FFFF;
    localparam logic [1:0]  FuncUnused = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    hash_key_dedup_counter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // table copy and register copy used for prediction
    logic [63:0] tab_lo   [TableDepth];
    logic [63:0] tab_hi   [TableDepth];
    logic [31:0] tab_cnt  [TableDepth];
    logic        tab_mark [TableDepth];
    int unsigned key_cnt;
    logic [31:0] peak_cnt;
    logic        cfg_both, cfg_abund;
    logic [31:0] cfg_min_len, cfg_max_len, cfg_min_uniq, cfg_max_uniq;

    t_in         req_q [$];
    t_out        result_q [$];
    logic [127:0] key_pool [$];

    int unsigned sent_cnt, recv_cnt, mism_cnt, cycle_cnt, median_cnt;
    int unsigned hold_left;
    bit          hold_done, in_taken;

    // ------------------------------------------------------------ predictor
    function automatic bit find_slot(input logic [63:0] lo, input logic [63:0] hi,
                                     output int unsigned slot);
        int unsigned b;
        b = lo % TableDepth;
        slot = b;
        for (int n = 0; n < TableDepth; n++) begin
            if (tab_cnt[b] == 0) begin
                slot = b;
                return 0;
            end
            if (tab_lo[b] == lo && tab_hi[b] == hi) begin
                slot = b;
                return 1;
            end
            b = (b + 1) % TableDepth;
        end
        return 0;
    endfunction

    function automatic bit find_key(input t_in r, output int unsigned slot);
        int unsigned alt;
        if (find_slot(r.key_plus_low, r.key_plus_high, slot)) return 1;
        if (cfg_both && find_slot(r.key_minus_low, r.key_minus_high, alt)) begin
            slot = alt;
            return 1;
        end
        return 0;
    endfunction

    // walk the candidate upward or downward through distinct counts
    function automatic logic [63:0] median_x2();
        logic [63:0] cand, lower, upper, v;
        logic [63:0] n_eq, n_lo, n_hi;
        cand = 1;
        lower = 0;
        upper = 0;
        for (int it = 0; it < TableDepth + 2; it++) begin
            n_eq = 0;
            n_lo = 0;
            n_hi = 0;
            for (int i = 0; i < TableDepth; i++) begin
                v = tab_cnt[i];
                if (v == 0) continue;
                if (v > cand) begin
                    if (n_hi == 0 || v < upper) upper = v;
                    n_hi++;
                end else if (v < cand) begin
                    if (n_lo == 0 || v > lower) lower = v;
                    n_lo++;
                end else begin
                    n_eq++;
                end
            end
            if (n_lo + n_eq + n_hi == 0) return 0;
            if (n_hi + n_eq >= n_lo) begin
                if (n_hi <= n_lo + n_eq) begin
                    if (n_hi == n_lo + n_eq) return cand + upper;
                    if (n_hi + n_eq == n_lo) return lower + cand;
                    return 2 * cand;
                end
                cand = upper;
            end else begin
                cand = lower;
            end
        end
        return 2 * cand;
    endfunction

    function automatic t_out predict_result(input t_in r);
        t_out        res;
        int unsigned slot;
        logic [32:0] sum, add;
        res = '0;
        res.status = ST_NOT_FOUND;
        slot = 0;
        if (r.func == FUNC_COUNT || r.func == FUNC_CLAIM) begin
            if (r.seq_length < cfg_min_len) begin
                res.status = ST_SHORT;
            end else if (r.seq_length > cfg_max_len) begin
                res.status = ST_LONG;
            end else if (r.func == FUNC_COUNT) begin
                add = 1;
                if (cfg_abund && r.abundance != 0) add = {2'b00, r.abundance};
                if (find_key(r, slot)) begin
                    sum = {1'b0, tab_cnt[slot]} + add;
                    tab_cnt[slot] = sum[32] ? AllOnes : sum[31:0];
                    res.status = ST_MATCHED;
                end else if (100 * (key_cnt + 1) > 95 * TableDepth || tab_cnt[slot] != 0) begin
                    res.status = ST_FULL;
                end else begin
                    tab_cnt[slot] = add[31:0];
                    tab_lo[slot] = r.key_plus_low;
                    tab_hi[slot] = r.key_plus_high;
                    tab_mark[slot] = 0;
                    key_cnt++;
                    res.status = ST_NEW;
                end
                if (res.status == ST_NEW || res.status == ST_MATCHED) begin
                    res.cluster_count = tab_cnt[slot];
                    res.bucket = 10'(slot);
                    if (tab_cnt[slot] > peak_cnt) peak_cnt = tab_cnt[slot];
                end
            end else if (find_key(r, slot)) begin
                res.cluster_count = tab_cnt[slot];
                res.bucket = 10'(slot);
                if (tab_mark[slot]) begin
                    res.status = ST_WRITTEN;
                end else begin
                    res.status = ST_MATCHED;
                    res.selected = tab_cnt[slot] >= cfg_min_uniq && tab_cnt[slot] <= cfg_max_uniq;
                    tab_mark[slot] = 1;
                end
            end
        end else if (r.func == FUNC_MEDIAN) begin
            res.status = ST_MATCHED;
            res.median_doubled = 33'(median_x2());
        end
        res.unique_keys = 11'(key_cnt);
        res.largest_count = peak_cnt;
        return res;
    endfunction

    // ------------------------------------------------------------ clock, driver, monitor
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_pct();
        return (sent_cnt >= 700 && sent_cnt < 900) ? 0 : 30;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || in_taken) begin
            if (req_q.size() > 0 && $urandom_range(99) >= idle_pct()) begin
                i_data <= req_q.pop_front();
                i_valid <= 1;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // long hold-off of the result side once, then random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 0;
        end else if (!hold_done && sent_cnt >= 300) begin
            hold_done = 1;
            hold_left = 400;
            i_ready <= 0;
        end else begin
            i_ready <= $urandom_range(99) >= idle_pct();
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mism_cnt++;
            if (mism_cnt <= 10)
                $display("mismatch beat %0d %s: expected %0h actual %0h",
                         recv_cnt, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
        in_taken = i_rst_n && i_valid && o_ready;
        if (in_taken) begin
            result_q.push_back(predict_result(i_data));
            sent_cnt++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                mism_cnt++;
                if (mism_cnt <= 10) $display("unexpected beat %0d", recv_cnt);
            end else begin
                want = result_q.pop_front();
                check_field("status", 64'(want.status), 64'(o_data.status));
                check_field("cluster_count", 64'(want.cluster_count),
                            64'(o_data.cluster_count));
                check_field("selected", 64'(want.selected), 64'(o_data.selected));
                check_field("bucket", 64'(want.bucket), 64'(o_data.bucket));
                check_field("median_doubled", 64'(want.median_doubled),
                            64'(o_data.median_doubled));
                check_field("unique_keys", 64'(want.unique_keys), 64'(o_data.unique_keys));
                check_field("largest_count", 64'(want.largest_count),
                            64'(o_data.largest_count));
            end
            recv_cnt++;
        end
    end

    // ------------------------------------------------------------ stimulus helpers
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // low key bits clustered near the table ends to force probe chains and wrap
    function automatic logic [127:0] fresh_key();
        logic [63:0] lo;
        lo = rand64();
        case ($urandom_range(3))
            0: lo[9:0] = 10'($urandom_range(1016, 1023));
            1: lo[9:0] = 10'($urandom_range(0, 7));
            default: ;
        endcase
        return {rand64(), lo};
    endfunction

    function automatic t_in mk_req(input logic [1:0] f, input logic [127:0] plus,
                                   input logic [127:0] minus, input logic [30:0] ab,
                                   input logic [31:0] len);
        t_in r;
        r.func = f;
        r.key_plus_low = plus[63:0];
        r.key_plus_high = plus[127:64];
        r.key_minus_low = minus[63:0];
        r.key_minus_high = minus[127:64];
        r.abundance = ab;
        r.seq_length = len;
        return r;
    endfunction

    function automatic logic [127:0] pool_key();
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_len();
        if ($urandom_range(99) < 85)
            return (cfg_max_len < cfg_min_len) ? cfg_min_len
                 : 32'({32'd0, cfg_min_len}
                       + ({32'd0, $urandom()} % ({32'd0, cfg_max_len - cfg_min_len} + 64'd1)));
        return $urandom();
    endfunction

    function automatic logic [30:0] pick_ab();
        return ($urandom_range(9) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 20));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_BOTH:     cfg_both = val[0];
            REG_ABUND:    cfg_abund = val[0];
            REG_MIN_LEN:  cfg_min_len = val;
            REG_MAX_LEN:  cfg_max_len = val;
            REG_MIN_UNIQ: cfg_min_uniq = val;
            REG_MAX_UNIQ: cfg_max_uniq = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (req_q.size() > 0 || i_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_all(input logic b, input logic a, input logic [31:0] lmin,
                           input logic [31:0] lmax, input logic [31:0] umin,
                           input logic [31:0] umax);
        write_reg(REG_BOTH, {31'd0, b});
        write_reg(REG_ABUND, {31'd0, a});
        write_reg(REG_MIN_LEN, lmin);
        write_reg(REG_MAX_LEN, lmax);
        write_reg(REG_MIN_UNIQ, umin);
        write_reg(REG_MAX_UNIQ, umax);
    endtask

    task automatic random_phase(input int n, input bit allow_median);
        logic [127:0] k;
        int unsigned  sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 20 || key_pool.size() == 0) begin
                k = fresh_key();
                key_pool.push_back(k);
                req_q.push_back(mk_req(FUNC_COUNT, k, fresh_key(), pick_ab(), pick_len()));
            end else if (sel < 65) begin
                req_q.push_back(mk_req(FUNC_COUNT, pool_key(), fresh_key(), pick_ab(),
                                       pick_len()));
            end else if (sel < 75) begin
                // reverse-complement side carries the stored key
                req_q.push_back(mk_req($urandom_range(1) ? FUNC_CLAIM : FUNC_COUNT,
                                       fresh_key(), pool_key(), pick_ab(), pick_len()));
            end else if (sel < 92) begin
                req_q.push_back(mk_req(FUNC_CLAIM, $urandom_range(4) ? pool_key() : fresh_key(),
                                       fresh_key(), pick_ab(), pick_len()));
            end else if (sel < 94 && allow_median && median_cnt < 12) begin
                median_cnt++;
                req_q.push_back(mk_req(FUNC_MEDIAN, fresh_key(), fresh_key(), pick_ab(),
                                       $urandom()));
            end else if (sel < 97) begin
                req_q.push_back(mk_req(FuncUnused, pool_key(), pool_key(), pick_ab(),
                                       $urandom()));
            end else begin
                req_q.push_back(mk_req(FUNC_COUNT, pool_key(), fresh_key(), pick_ab(),
                                       $urandom()));
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------ test sequence
    initial begin
        logic [127:0] k0, k1, k2, edge_a, edge_b;
        for (int i = 0; i < TableDepth; i++) begin
            tab_lo[i] = 0;
            tab_hi[i] = 0;
            tab_cnt[i] = 0;
            tab_mark[i] = 0;
        end
        key_cnt = 0;
        peak_cnt = 0;
        cfg_both = 0;
        cfg_abund = 0;
        cfg_min_len = 1;
        cfg_max_len = AllOnes;
        cfg_min_uniq = 1;
        cfg_max_uniq = AllOnes;
        sent_cnt = 0;
        recv_cnt = 0;
        mism_cnt = 0;
        cycle_cnt = 0;
        median_cnt = 0;
        hold_left = 0;
        hold_done = 0;
        in_taken = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_data = '0;
        i_cfg_we = 0;
        i_cfg_index = REG_BOTH;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed, reset settings
        k0 = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};  // home bucket 1023
        k1 = {64'h0, 64'h0000_0000_0000_03FF};                  // same bucket, wraps to 0
        k2 = {64'h0, 64'h0};
        key_pool.push_back(k0);
        key_pool.push_back(k1);
        key_pool.push_back(k2);
        req_q.push_back(mk_req(FUNC_MEDIAN, k0, k0, 0, 0));       // empty table
        req_q.push_back(mk_req(FUNC_CLAIM, k0, k1, 0, 5));        // claim miss
        req_q.push_back(mk_req(FUNC_COUNT, k0, k1, 31'h7FFF_FFFF, AllOnes));
        req_q.push_back(mk_req(FUNC_COUNT, k1, k0, 0, 1));
        req_q.push_back(mk_req(FUNC_COUNT, k2, k2, 0, 1));        // bucket 0 now taken
        req_q.push_back(mk_req(FUNC_COUNT, k0, k1, 0, 7));
        req_q.push_back(mk_req(FUNC_COUNT, k1, k1, 0, 0));        // too short
        req_q.push_back(mk_req(FuncUnused, k0, k0, 0, 7));        // unknown selector
        req_q.push_back(mk_req(FUNC_CLAIM, k0, k1, 0, 7));
        req_q.push_back(mk_req(FUNC_CLAIM, k0, k1, 0, 7));        // repeat claim
        req_q.push_back(mk_req(FUNC_COUNT, k0, k1, 0, 7));        // counted after claim
        req_q.push_back(mk_req(FUNC_MEDIAN, k0, k0, 0, 0));
        drain();

        // directed, opposite extremes
        set_all(1, 1, 100, 200, 2, 50);
        edge_a = fresh_key();
        edge_b = fresh_key();
        key_pool.push_back(edge_b);
        req_q.push_back(mk_req(FUNC_COUNT, edge_a, k1, 31'd0, 100));  // found by minus key
        req_q.push_back(mk_req(FUNC_COUNT, edge_b, edge_a, 31'h7FFF_FFFF, 200));
        req_q.push_back(mk_req(FUNC_COUNT, edge_b, edge_a, 31'h7FFF_FFFF, 150));
        req_q.push_back(mk_req(FUNC_COUNT, edge_b, edge_a, 31'h7FFF_FFFF, 150)); // saturate
        req_q.push_back(mk_req(FUNC_COUNT, edge_a, edge_a, 1, 99));   // too short
        req_q.push_back(mk_req(FUNC_COUNT, edge_a, edge_a, 1, 201));  // too long
        req_q.push_back(mk_req(FUNC_CLAIM, edge_a, k2, 0, 150));      // claim through minus
        req_q.push_back(mk_req(FUNC_CLAIM, edge_b, k2, 0, 150));      // above unique limit
        req_q.push_back(mk_req(FUNC_CLAIM, k2, k2, 0, 201));
        req_q.push_back(mk_req(FUNC_MEDIAN, k0, k0, 0, 0));
        drain();

        set_all(0, 0, 0, AllOnes, 0, AllOnes);
        random_phase(140, 1);
        set_all(1, 1, 50, 5000, 3, 10);
        random_phase(140, 1);
        set_all(1, 0, AllOnes, AllOnes, AllOnes, AllOnes);
        random_phase(80, 0);
        set_all(0, 1, 0, 0, 0, 0);
        random_phase(80, 1);

        // fill until inserts are refused, then keep counting and claiming existing keys
        set_all(0, 0, 1, AllOnes, 1, 1);
        for (int i = 0; i < 950; i++) begin
            k0 = {rand64(), rand64()};
            key_pool.push_back(k0);
            req_q.push_back(mk_req(FUNC_COUNT, k0, k0, 0, 1));
        end
        for (int i = 0; i < 40; i++)
            req_q.push_back(mk_req($urandom_range(1) ? FUNC_CLAIM : FUNC_COUNT, pool_key(),
                                   fresh_key(), 0, 1));
        req_q.push_back(mk_req(FUNC_MEDIAN, k0, k0, 0, 0));
        drain();

        $display("covered %0d requests in %0d cycles: counts, claims, medians, length filters,",
                 sent_cnt, cycle_cnt);
        $display("both-strand lookup, saturation, probe wrap and a full table; %0d mismatches",
                 mism_cnt);
        if (mism_cnt == 0 && result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
